>>> rtl/core/resa_pkg.sv
// ----------------------------------------------------------------------------
// resa_pkg
// Shared types and constants of the rotary encoder step accelerator: the
// register map, the register reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package resa_pkg;

    // Width of every configuration register and of the step field.
    localparam int REG_W  = 16;
    localparam int STEP_W = 17;

    // APB data and address widths.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_FAST_LIMIT = 3'd0,
        REG_MID_LIMIT  = 3'd1,
        REG_SLOW_LIMIT = 3'd2,
        REG_FAST_GAIN  = 3'd3,
        REG_MID_GAIN   = 3'd4,
        REG_SLOW_GAIN  = 3'd5
    } reg_idx_t;

    // Register reset values.
    localparam logic [REG_W-1:0] FAST_LIMIT_RST = 16'd50;
    localparam logic [REG_W-1:0] MID_LIMIT_RST  = 16'd100;
    localparam logic [REG_W-1:0] SLOW_LIMIT_RST = 16'd200;
    localparam logic [REG_W-1:0] FAST_GAIN_RST  = 16'd1000;
    localparam logic [REG_W-1:0] MID_GAIN_RST   = 16'd100;
    localparam logic [REG_W-1:0] SLOW_GAIN_RST  = 16'd10;

    // Gain used when no speed limit is met.
    localparam logic [REG_W-1:0] UNITY_GAIN = 16'd1;

    // Configuration bundle handed to the detent calculation.
    typedef struct packed {
        logic [REG_W-1:0] fast_limit_ms;
        logic [REG_W-1:0] mid_limit_ms;
        logic [REG_W-1:0] slow_limit_ms;
        logic [REG_W-1:0] fast_gain;
        logic [REG_W-1:0] mid_gain;
        logic [REG_W-1:0] slow_gain;
    } cfg_t;

endpackage

>>> rtl/core/resa_detent_calc.sv
// ----------------------------------------------------------------------------
// resa_detent_calc
// Detent detection, interval measurement, leaky interval sum update and
// gain selection for one encoder sample. Purely combinational.
// ----------------------------------------------------------------------------
module resa_detent_calc #(
    parameter int TIME_WIDTH = 32
) (
    input  resa_pkg::cfg_t                     cfg,
    input  logic                               prev_a,
    input  logic                               level_a,
    input  logic                               level_b,
    input  logic [TIME_WIDTH-1:0]              now_t,
    input  logic [TIME_WIDTH-1:0]              last_time,
    input  logic [TIME_WIDTH-1:0]              sum,
    output logic                               detent,
    output logic [TIME_WIDTH-1:0]              sum_next,
    output logic signed [resa_pkg::STEP_W-1:0] step
);

    localparam int AVG_W = TIME_WIDTH - 2;
    localparam int CMP_W = AVG_W + resa_pkg::REG_W;

    logic [TIME_WIDTH-1:0]        interval;
    logic [TIME_WIDTH-1:0]        decayed;
    logic [CMP_W-1:0]             avg_cmp;
    logic [resa_pkg::REG_W-1:0]   gain;
    logic [resa_pkg::STEP_W-1:0]  gain_ext;

    // A detent is a rising edge on channel A.
    assign detent = !prev_a && level_a;

    // Interval since the previous detent and the leaky sum, both wrapping.
    assign interval = now_t - last_time;
    assign decayed  = sum - (sum >> 2);
    assign sum_next = decayed + interval;

    // Average interval, widened so it compares directly with a limit.
    assign avg_cmp = {{resa_pkg::REG_W{1'b0}}, sum_next[TIME_WIDTH-1:2]};

    // Limits are tested fast, mid, slow; the first one met picks the gain.
    always_comb
    begin
        if (avg_cmp < {{AVG_W{1'b0}}, cfg.fast_limit_ms})
        begin
            gain = cfg.fast_gain;
        end
        else if (avg_cmp < {{AVG_W{1'b0}}, cfg.mid_limit_ms})
        begin
            gain = cfg.mid_gain;
        end
        else if (avg_cmp < {{AVG_W{1'b0}}, cfg.slow_limit_ms})
        begin
            gain = cfg.slow_gain;
        end
        else
        begin
            gain = resa_pkg::UNITY_GAIN;
        end
    end

    // Direction comes from channel B; no detent gives a zero step.
    assign gain_ext = {1'b0, gain};

    always_comb
    begin
        if (!detent)
        begin
            step = '0;
        end
        else if (level_b)
        begin
            step = gain_ext;
        end
        else
        begin
            step = -gain_ext;
        end
    end

endmodule

>>> rtl/core/rotary_encoder_step_accelerator.sv
// ----------------------------------------------------------------------------
// rotary_encoder_step_accelerator
// Turns sampled encoder pin levels into signed, speed-scaled rotation steps.
// ----------------------------------------------------------------------------
// Every accepted sample produces exactly one step result, in order. A sample
// is captured in an input register; when the result register is free or
// being read out, the detent logic updates the edge, time and leaky sum state
// and loads the result register, so a new sample can be taken every cycle
// while out_ready keeps up. The per-sample cost is set by one chain of logic:
// the interval subtract, the leaky sum add and the three limit compares.
// Registers are to be written through the APB port only while the block is
// idle; the block does not enforce this. They take effect for the next sample.
module rotary_encoder_step_accelerator #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Sample channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   level_a,
    input  logic                                   level_b,
    input  logic [31:0]                            now_ms,
    // Step channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [resa_pkg::STEP_W-1:0]     step,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [resa_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [resa_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [resa_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int PAD_W = resa_pkg::APB_DATA_W - resa_pkg::REG_W;

    resa_pkg::cfg_t                          cfg_reg;
    logic                                    cfg_write;

    logic                                    s1_valid_reg;
    logic                                    s1_a_reg;
    logic                                    s1_b_reg;
    logic [TIME_WIDTH-1:0]                   s1_now_reg;
    logic [TIME_WIDTH+31:0]                  now_wide;

    logic                                    prev_a_reg;
    logic [TIME_WIDTH-1:0]                   last_detent_time_reg;
    logic [TIME_WIDTH-1:0]                   sum_reg;

    logic                                    out_valid_reg;
    logic signed [resa_pkg::STEP_W-1:0]      step_reg;

    logic                                    advance;
    logic                                    detent;
    logic [TIME_WIDTH-1:0]                   sum_next;
    logic signed [resa_pkg::STEP_W-1:0]      step_next;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_limit_ms <= resa_pkg::FAST_LIMIT_RST;
            cfg_reg.mid_limit_ms  <= resa_pkg::MID_LIMIT_RST;
            cfg_reg.slow_limit_ms <= resa_pkg::SLOW_LIMIT_RST;
            cfg_reg.fast_gain     <= resa_pkg::FAST_GAIN_RST;
            cfg_reg.mid_gain      <= resa_pkg::MID_GAIN_RST;
            cfg_reg.slow_gain     <= resa_pkg::SLOW_GAIN_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                resa_pkg::REG_FAST_LIMIT: cfg_reg.fast_limit_ms <= pwdata[15:0];
                resa_pkg::REG_MID_LIMIT:  cfg_reg.mid_limit_ms  <= pwdata[15:0];
                resa_pkg::REG_SLOW_LIMIT: cfg_reg.slow_limit_ms <= pwdata[15:0];
                resa_pkg::REG_FAST_GAIN:  cfg_reg.fast_gain     <= pwdata[15:0];
                resa_pkg::REG_MID_GAIN:   cfg_reg.mid_gain      <= pwdata[15:0];
                resa_pkg::REG_SLOW_GAIN:  cfg_reg.slow_gain     <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[4:2])
            resa_pkg::REG_FAST_LIMIT: prdata = {{PAD_W{1'b0}}, cfg_reg.fast_limit_ms};
            resa_pkg::REG_MID_LIMIT:  prdata = {{PAD_W{1'b0}}, cfg_reg.mid_limit_ms};
            resa_pkg::REG_SLOW_LIMIT: prdata = {{PAD_W{1'b0}}, cfg_reg.slow_limit_ms};
            resa_pkg::REG_FAST_GAIN:  prdata = {{PAD_W{1'b0}}, cfg_reg.fast_gain};
            resa_pkg::REG_MID_GAIN:   prdata = {{PAD_W{1'b0}}, cfg_reg.mid_gain};
            resa_pkg::REG_SLOW_GAIN:  prdata = {{PAD_W{1'b0}}, cfg_reg.slow_gain};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    // The sample stage moves on whenever the result register is free or
    // its result is being transferred out.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    // Timestamp resized to the internal time width.
    assign now_wide = {{TIME_WIDTH{1'b0}}, now_ms};

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_a_reg   <= level_a;
            s1_b_reg   <= level_b;
            s1_now_reg <= now_wide[TIME_WIDTH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Detent calculation
    // ------------------------------------------------------------------
    resa_detent_calc #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_calc (
        .cfg       (cfg_reg),
        .prev_a    (prev_a_reg),
        .level_a   (s1_a_reg),
        .level_b   (s1_b_reg),
        .now_t     (s1_now_reg),
        .last_time (last_detent_time_reg),
        .sum       (sum_reg),
        .detent    (detent),
        .sum_next  (sum_next),
        .step      (step_next)
    );

    // Encoder state, updated as each sample leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg           <= 1'b0;
            last_detent_time_reg <= '0;
            sum_reg              <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            prev_a_reg <= s1_a_reg;
            if (detent)
            begin
                last_detent_time_reg <= s1_now_reg;
                sum_reg              <= sum_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            step_reg <= step_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign step      = step_reg;

`ifndef SYNTH
    // A sample without a rising edge on A yields a zero step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && !detent) |=> (step_reg == '0))
        else $error("step is nonzero for a sample without a detent");

    // The detent time only moves when a detent leaves the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && advance && detent) |=> $stable(last_detent_time_reg))
        else $error("detent time changed without a detent");

    // The previous level of A follows each sample that moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> (prev_a_reg == $past(s1_a_reg)))
        else $error("previous A level does not follow the sample");
`endif

endmodule

>>> verif/resa_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resa_step_checker
// Watches the sample, step and configuration ports of the step accelerator.
// It keeps its own copy of the speed bands and of the detent state, works out
// the step of every sample transfer and compares it with the step transfers.
// ----------------------------------------------------------------------------
module resa_step_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   level_a,
    input  logic                                   level_b,
    input  logic [31:0]                            now_ms,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [resa_pkg::STEP_W-1:0]     step,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [resa_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [resa_pkg::APB_DATA_W-1:0]        pwdata,
    input  logic                                   pready,
    output int                                     mismatch_count,
    output int                                     outstanding
);

    // Mirror of the speed band registers and of the detent tracking state.
    resa_pkg::cfg_t                         bands;
    logic                                   a_was_high;
    logic [31:0]                            last_detent_ms;
    logic [31:0]                            leaky_sum_ms;

    // Steps still owed by the block, oldest first.
    logic signed [resa_pkg::STEP_W-1:0]     pending_steps[$];

    // Updates the detent state for one sample and returns its scaled step.
    function automatic logic signed [resa_pkg::STEP_W-1:0] scaled_step(
        input logic        a,
        input logic        b,
        input logic [31:0] t
    );
        logic [31:0]                  interval;
        logic [31:0]                  average;
        logic [resa_pkg::REG_W-1:0]   gain;
        logic [resa_pkg::STEP_W-1:0]  result;
        result = '0;
        if (!a_was_high && a)
        begin
            // Interval and leaky sum both wrap at 32 bits.
            interval     = t - last_detent_ms;
            leaky_sum_ms = leaky_sum_ms - (leaky_sum_ms >> 2) + interval;
            average      = leaky_sum_ms >> 2;
            // First band met wins, whatever the order of the limits.
            if (average < {16'd0, bands.fast_limit_ms})
                gain = bands.fast_gain;
            else if (average < {16'd0, bands.mid_limit_ms})
                gain = bands.mid_gain;
            else if (average < {16'd0, bands.slow_limit_ms})
                gain = bands.slow_gain;
            else
                gain = resa_pkg::UNITY_GAIN;
            result         = b ? {1'b0, gain} : 17'd0 - {1'b0, gain};
            last_detent_ms = t;
        end
        a_was_high = a;
        return result;
    endfunction

    // Track register writes, predict on sample transfers, check step transfers.
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [resa_pkg::STEP_W-1:0] want;
        if (!rst_n)
        begin
            bands.fast_limit_ms = resa_pkg::FAST_LIMIT_RST;
            bands.mid_limit_ms  = resa_pkg::MID_LIMIT_RST;
            bands.slow_limit_ms = resa_pkg::SLOW_LIMIT_RST;
            bands.fast_gain     = resa_pkg::FAST_GAIN_RST;
            bands.mid_gain      = resa_pkg::MID_GAIN_RST;
            bands.slow_gain     = resa_pkg::SLOW_GAIN_RST;
            a_was_high          = 1'b0;
            last_detent_ms      = '0;
            leaky_sum_ms        = '0;
            pending_steps.delete();
            mismatch_count     <= 0;
            outstanding        <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    resa_pkg::REG_FAST_LIMIT: bands.fast_limit_ms = pwdata[15:0];
                    resa_pkg::REG_MID_LIMIT:  bands.mid_limit_ms  = pwdata[15:0];
                    resa_pkg::REG_SLOW_LIMIT: bands.slow_limit_ms = pwdata[15:0];
                    resa_pkg::REG_FAST_GAIN:  bands.fast_gain     = pwdata[15:0];
                    resa_pkg::REG_MID_GAIN:   bands.mid_gain      = pwdata[15:0];
                    resa_pkg::REG_SLOW_GAIN:  bands.slow_gain     = pwdata[15:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                pending_steps.push_back(scaled_step(level_a, level_b, now_ms));

            if (out_valid && out_ready)
            begin
                if (pending_steps.size() == 0)
                begin
                    $error("step: no transfer expected, actual %0d", step);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = pending_steps.pop_front();
                    if (step !== want)
                    begin
                        $error("step: expected %0d, actual %0d", want, step);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end

            outstanding <= pending_steps.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives encoder samples and register writes into the step accelerator.
// Directed samples cover the first detent, held and falling levels, both
// directions, timestamp wrap, a zero gain, unordered limits and writes to
// unmapped addresses. Random turns at speeds around the band limits follow,
// mixed with noise, under several band settings with bursty input and a
// stalling receiver. The checker beside the block predicts every step.
// ----------------------------------------------------------------------------
module tb;

    localparam int          STALL_LIMIT       = 2000;
    localparam int          SETTLE_CYCLES     = 8;
    localparam int          RANDOM_SAMPLES    = 750;
    localparam int          SAMPLES_PER_PHASE = 125;
    localparam logic [2:0]  UNMAPPED_LOW_IDX  = 3'd6;
    localparam logic [2:0]  UNMAPPED_HIGH_IDX = 3'd7;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_ready;
    logic                                   level_a;
    logic                                   level_b;
    logic [31:0]                            now_ms;
    logic                                   out_valid;
    logic                                   out_ready;
    logic signed [resa_pkg::STEP_W-1:0]     step;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [resa_pkg::APB_ADDR_W-1:0]        paddr;
    logic [resa_pkg::APB_DATA_W-1:0]        pwdata;
    logic [resa_pkg::APB_DATA_W-1:0]        prdata;
    logic                                   pready;

    int                                     mismatch_count;
    int                                     outstanding;
    int                                     idle_cycles;
    int                                     burst_left;
    int                                     samples_sent;
    logic [31:0]                            clock_ms;
    logic [15:0]                            fast_band_ms;
    logic [15:0]                            slow_band_ms;

    rotary_encoder_step_accelerator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .level_a   (level_a),
        .level_b   (level_b),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .step      (step),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    resa_step_checker step_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .level_a        (level_a),
        .level_b        (level_b),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .step           (step),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Ends the run when no transfer of any kind happens for too long.
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: ready steps through a 16-bit pattern, redrawn periodically as all ones, 16'h8001 or random.
    initial
    begin
        logic [15:0] ready_pattern;
        int          ready_phase;
        ready_pattern = 16'hFFFF;
        ready_phase   = 0;
        out_ready    <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_phase % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'h8001;
                    default: ready_pattern = 16'($urandom);
                endcase
            end
            out_ready   <= ready_pattern[ready_phase % 16];
            ready_phase  = ready_phase + 1;
        end
    end

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes all six speed band registers and remembers the fast and slow limits
    // used to aim the turning speed.
    task automatic load_speed_bands(
        input logic [15:0] fast_lim,
        input logic [15:0] mid_lim,
        input logic [15:0] slow_lim,
        input logic [15:0] fast_g,
        input logic [15:0] mid_g,
        input logic [15:0] slow_g
    );
        write_reg(resa_pkg::REG_FAST_LIMIT, fast_lim);
        write_reg(resa_pkg::REG_MID_LIMIT, mid_lim);
        write_reg(resa_pkg::REG_SLOW_LIMIT, slow_lim);
        write_reg(resa_pkg::REG_FAST_GAIN, fast_g);
        write_reg(resa_pkg::REG_MID_GAIN, mid_g);
        write_reg(resa_pkg::REG_SLOW_GAIN, slow_g);
        fast_band_ms = fast_lim;
        slow_band_ms = slow_lim;
    endtask

    // Holds off new samples until every step has come back.
    task automatic drain_steps();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // One sample transfer, with a random gap between bursts.
    task automatic feed(input logic a, input logic b, input logic [31:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left   = burst_left - 1;
        level_a     <= a;
        level_b     <= b;
        now_ms      <= t;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent = samples_sent + 1;
    endtask

    // A turn of several detents at a steady interval in one direction.
    task automatic turn(input logic dir, input logic [31:0] interval, input int detents);
        repeat (detents)
        begin
            clock_ms = clock_ms + interval;
            feed(1'b0, 1'($urandom), clock_ms - (interval >> 1));
            feed(1'b1, dir, clock_ms);
            // Sometimes A stays high for another sample.
            if ($urandom_range(0, 3) == 0)
                feed(1'b1, 1'($urandom), clock_ms);
        end
    endtask

    // Interval aimed at the current speed bands, with some wild ones.
    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1, 2, 3: return $urandom_range(0, 2 * int'(fast_band_ms) + 1);
            8:       return $urandom_range(0, 100000);
            9:       return $urandom;
            default: return $urandom_range(0, int'(slow_band_ms) + int'(slow_band_ms) / 2 + 8);
        endcase
    endfunction

    // Stimulus.
    initial
    begin
        int kind;
        int phase_start;
        in_valid     <= 1'b0;
        level_a      <= 1'b0;
        level_b      <= 1'b0;
        now_ms       <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        rst_n        <= 1'b0;
        burst_left   = 0;
        samples_sent = 0;
        fast_band_ms = resa_pkg::FAST_LIMIT_RST;
        slow_band_ms = resa_pkg::SLOW_LIMIT_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First detent is timed from zero; held high and falling A give no step.
        feed(1'b0, 1'b0, 32'd0);
        feed(1'b1, 1'b1, 32'd20);
        feed(1'b1, 1'b0, 32'd25);
        feed(1'b0, 1'b1, 32'd30);
        feed(1'b1, 1'b0, 32'd60);
        // Timestamp extremes and wrap across zero.
        feed(1'b0, 1'b1, 32'hFFFF_FFF0);
        feed(1'b1, 1'b1, 32'hFFFF_FFFF);
        feed(1'b0, 1'b0, 32'hFFFF_FFFF);
        feed(1'b1, 1'b1, 32'h0000_0010);
        clock_ms = 32'h0000_0010;
        turn(1'b1, 32'd2, 4);

        // Zero gain in the winning band, unordered limits, unmapped writes.
        drain_steps();
        load_speed_bands(16'd300, 16'd20, 16'd10, 16'd0, 16'hFFFF, 16'hFFFF);
        write_reg(UNMAPPED_LOW_IDX, 16'h1234);
        write_reg(UNMAPPED_HIGH_IDX, 16'hFFFF);
        turn(1'b0, 32'd30, 4);

        // Random phases, each with its own speed bands.
        phase_start = samples_sent;
        while (samples_sent - phase_start < RANDOM_SAMPLES)
        begin
            drain_steps();
            case ($urandom_range(0, 5))
                0: load_speed_bands(resa_pkg::FAST_LIMIT_RST, resa_pkg::MID_LIMIT_RST,
                                    resa_pkg::SLOW_LIMIT_RST, resa_pkg::FAST_GAIN_RST,
                                    resa_pkg::MID_GAIN_RST, resa_pkg::SLOW_GAIN_RST);
                1: load_speed_bands(16'd0, 16'd0, 16'd0, 16'($urandom), 16'($urandom),
                                    16'($urandom));
                2: load_speed_bands(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF);
                3:
                begin
                    int f;
                    int m;
                    f = $urandom_range(0, 300);
                    m = f + $urandom_range(0, 300);
                    load_speed_bands(16'(f), 16'(m), 16'(m + $urandom_range(0, 300)),
                                     16'($urandom), 16'($urandom), 16'($urandom));
                end
                4: load_speed_bands(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom));
                default: load_speed_bands(16'($urandom_range(0, 100)),
                                          16'($urandom_range(0, 200)),
                                          16'($urandom_range(0, 400)), 16'd0, 16'd0,
                                          16'($urandom_range(0, 3)));
            endcase
            if ($urandom_range(0, 3) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);

            kind = samples_sent;
            while (samples_sent - kind < SAMPLES_PER_PHASE)
            begin
                case ($urandom_range(0, 9))
                    7, 8:
                    begin
                        // Noise: arbitrary levels and timestamps.
                        repeat ($urandom_range(1, 6))
                            feed(1'($urandom), 1'($urandom), $urandom);
                    end
                    9:
                    begin
                        // Broken turn: A high for two samples, then low for two.
                        clock_ms = clock_ms + pick_interval();
                        feed(1'b1, 1'($urandom), clock_ms);
                        feed(1'b1, 1'($urandom), clock_ms + 1);
                        feed(1'b0, 1'($urandom), clock_ms + 2);
                        feed(1'b0, 1'($urandom), clock_ms + 3);
                    end
                    default: turn(1'($urandom), pick_interval(), $urandom_range(1, 8));
                endcase
            end
        end

        drain_steps();
        if (mismatch_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
